// File: src/gha_pkg.sv
// Shared types and codes for the generation handle allocator.
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned GEN_W     = 8;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned REL_W     = 16;
  localparam int unsigned OUTCOME_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC       = 2'd0,
    CMD_REUSE       = 2'd1,
    CMD_RELEASE     = 2'd2,
    CMD_RELEASE_ALT = 2'd3
  } cmd_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_NEW      = 2'd0,
    OUTCOME_KEPT     = 2'd1,
    OUTCOME_FULL     = 2'd2,
    OUTCOME_RELEASED = 2'd3
  } outcome_t;

  typedef struct packed {
    logic             accept;
    logic             is_release;
    logic             is_reuse;
    logic [TAG_W-1:0] hin_tag;
    logic [GEN_W-1:0] hin_gen;
  } gha_req_t;

endpackage

`default_nettype wire

// File: src/gha_cell.sv
// One slot of the allocator: use bit, generation count and its link in the free-slot chain.
`timescale 1ns / 1ps
`default_nettype none

module gha_cell #(
  parameter int unsigned SLOT_IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gha_pkg::gha_req_t             req,
  input  wire logic                          release_bit,
  input  wire logic                          alloc_en,
  input  wire logic                          taken_in,
  output logic                               taken_out,
  output logic                               hit,
  output logic                               grant,
  output logic [gha_pkg::HANDLE_W-1:0]       grant_handle
);
  import gha_pkg::*;

  localparam logic [TAG_W-1:0] SLOT_TAG = TAG_W'(SLOT_IDX + 1);

  logic             in_use_r;
  logic             in_use_nxt;
  logic [GEN_W-1:0] gen_r;
  logic [GEN_W-1:0] gen_nxt;
  logic [GEN_W-1:0] gen_inc;

  assign gen_inc      = gen_r + GEN_W'(1);
  assign taken_out    = taken_in | ~in_use_r;
  assign grant        = alloc_en & ~in_use_r & ~taken_in;
  assign hit          = req.is_reuse & in_use_r & (req.hin_tag == SLOT_TAG)
                        & (req.hin_gen == gen_r);
  assign grant_handle = grant ? {gen_inc, SLOT_TAG} : '0;

  always_comb begin
    in_use_nxt = in_use_r;
    gen_nxt    = gen_r;
    if (req.accept) begin
      if (req.is_release) begin
        if (release_bit) begin
          in_use_nxt = 1'b0;
        end
      end else if (grant) begin
        in_use_nxt = 1'b1;
        gen_nxt    = gen_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      gen_r    <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      gen_r    <= gen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/generation_handle_allocator.sv
// Top level of the generation handle allocator: a row of slot cells and the result register.
// The result of an accepted item is registered and appears in the output register in the next cycle.
// Throughput: one item per cycle; the free-slot search ripples through the row of slot cells.
// The input stalls only while a held result is itself stalled.
// Reset is synchronous and active low, and it clears all use bits and generation counts.
`timescale 1ns / 1ps
`default_nettype none

module generation_handle_allocator #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [gha_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [gha_pkg::HANDLE_W-1:0]    in_handle_in,
  input  wire logic [gha_pkg::REL_W-1:0]       in_release_mask,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [gha_pkg::HANDLE_W-1:0]         out_handle_out,
  output logic [gha_pkg::OUTCOME_W-1:0]        out_outcome
);
  import gha_pkg::*;

  gha_req_t              req;
  logic                  accept;
  logic                  alloc_en;
  logic                  any_hit;
  logic                  any_grant;
  logic [SLOT_COUNT:0]   taken;
  logic [SLOT_COUNT-1:0] hits;
  logic [SLOT_COUNT-1:0] grants;
  logic [SLOT_COUNT-1:0] rel_bits;
  logic [HANDLE_W-1:0]   cell_handle [SLOT_COUNT];
  logic [HANDLE_W-1:0]   new_handle;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [HANDLE_W-1:0]   handle_r;
  logic [HANDLE_W-1:0]   handle_nxt;
  outcome_t              outcome_r;
  outcome_t              outcome_nxt;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    req            = '0;
    req.accept     = accept;
    req.is_release = in_cmd inside {CMD_RELEASE, CMD_RELEASE_ALT};
    req.is_reuse   = (in_cmd == CMD_REUSE);
    req.hin_tag    = in_handle_in[TAG_W-1:0];
    req.hin_gen    = in_handle_in[HANDLE_W-1:TAG_W];
  end

  assign any_hit  = |hits;
  assign alloc_en = accept & ~req.is_release & ~any_hit;
  assign taken[0] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < SLOT_COUNT; i++) begin : g_slot
      if (i < REL_W) begin : g_rel
        assign rel_bits[i] = in_release_mask[i];
      end else begin : g_norel
        assign rel_bits[i] = 1'b0;
      end

      gha_cell #(
        .SLOT_IDX(i)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .release_bit  (rel_bits[i]),
        .alloc_en     (alloc_en),
        .taken_in     (taken[i]),
        .taken_out    (taken[i+1]),
        .hit          (hits[i]),
        .grant        (grants[i]),
        .grant_handle (cell_handle[i])
      );
    end
  endgenerate

  assign any_grant = |grants;

  always_comb begin
    new_handle = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      new_handle = new_handle | cell_handle[k];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    handle_nxt    = handle_r;
    outcome_nxt   = outcome_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (req.is_release) begin
        handle_nxt  = '0;
        outcome_nxt = OUTCOME_RELEASED;
      end else if (any_hit) begin
        handle_nxt  = in_handle_in;
        outcome_nxt = OUTCOME_KEPT;
      end else if (any_grant) begin
        handle_nxt  = new_handle;
        outcome_nxt = OUTCOME_NEW;
      end else begin
        handle_nxt  = '0;
        outcome_nxt = OUTCOME_FULL;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r  <= handle_nxt;
    outcome_r <= outcome_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = handle_r;
  assign out_outcome    = outcome_r;

endmodule

`default_nettype wire

// File: src/gha_checker.sv
// Port-level checks for the generation handle allocator and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module gha_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [gha_pkg::HANDLE_W-1:0]  out_handle_out,
  input wire logic [gha_pkg::OUTCOME_W-1:0] out_outcome
);
  import gha_pkg::*;

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while no result was held.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("Accepted item produced no result.");

  a_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == OUTCOME_FULL || out_outcome == OUTCOME_RELEASED))
    |-> (out_handle_out == '0))
    else $error("Full or release item carries a nonzero handle.");

  a_new_handle_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == OUTCOME_NEW) |-> (out_handle_out[TAG_W-1:0] != '0))
    else $error("New handle has a zero slot field.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_handle_out)
                                  && $stable(out_outcome)))
    else $error("Stalled result changed.");

endmodule

bind generation_handle_allocator gha_checker u_gha_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_handle_out (out_handle_out),
  .out_outcome    (out_outcome)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the generation handle allocator: directed and random items against a scoreboard.
`timescale 1ns / 1ps

import gha_pkg::*;

typedef struct packed {
  logic [HANDLE_W-1:0] handle;
  outcome_t            outcome;
} handle_result_t;

class handle_ledger;
  localparam int SLOTS = 16;
  localparam int RECENT_DEPTH = 16;

  logic [SLOTS-1:0] slot_used;
  logic [GEN_W-1:0] slot_gen [SLOTS];
  handle_result_t   due_results [$];
  logic [HANDLE_W-1:0] recent_handles [$];
  int mismatches;

  function new();
    slot_used = '0;
    foreach (slot_gen[i]) slot_gen[i] = '0;
    mismatches = 0;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function bit handle_live(logic [HANDLE_W-1:0] h);
    int slot;
    if (h[7:0] == 8'd0 || h[7:0] > SLOTS) return 1'b0;
    slot = h[7:0] - 1;
    return slot_used[slot] && slot_gen[slot] == h[15:8];
  endfunction

  function void note_request(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] hin,
                             logic [REL_W-1:0] rel);
    handle_result_t r;
    int slot;
    r.handle = '0;
    r.outcome = OUTCOME_FULL;
    if (cmd[1]) begin
      slot_used = slot_used & ~rel;
      r.outcome = OUTCOME_RELEASED;
    end else if (cmd == CMD_REUSE && handle_live(hin)) begin
      r.handle = hin;
      r.outcome = OUTCOME_KEPT;
    end else begin
      slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_used[i]) slot = i;
      end
      if (slot >= 0) begin
        slot_used[slot] = 1'b1;
        slot_gen[slot] = slot_gen[slot] + 8'd1;
        r.handle = {slot_gen[slot], 8'(slot + 1)};
        r.outcome = OUTCOME_NEW;
        recent_handles.push_back(r.handle);
        if (recent_handles.size() > RECENT_DEPTH) void'(recent_handles.pop_front());
      end
    end
    due_results.push_back(r);
  endfunction

  task check_result(logic [HANDLE_W-1:0] h, logic [OUTCOME_W-1:0] oc);
    handle_result_t r;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result %h/%0d arrived with nothing expected", h, oc));
      return;
    end
    r = due_results.pop_front();
    if (h !== r.handle)
      report_mismatch($sformatf("handle_out %h, expected %h", h, r.handle));
    if (oc !== r.outcome)
      report_mismatch($sformatf("outcome %0d, expected %0d", oc, r.outcome));
  endtask
endclass

module tb;
  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 48;
  localparam int TAIL_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = CMD_ALLOC;
  logic [HANDLE_W-1:0] in_handle_in = '0;
  logic [REL_W-1:0] in_release_mask = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [OUTCOME_W-1:0] out_outcome;

  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  handle_ledger ledger;

  generation_handle_allocator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_handle_in(in_handle_in),
    .in_release_mask(in_release_mask),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_handle_out(out_handle_out),
    .out_outcome(out_outcome)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.note_request(in_cmd, in_handle_in, in_release_mask);
      if (out_valid && !out_stall) ledger.check_result(out_handle_out, out_outcome);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 24);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] hin,
                           input logic [REL_W-1:0] mask);
    if (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_handle_in <= hin;
    in_release_mask <= mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (ledger.pending() != 0);
    @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(CMD_ALLOC, 16'($urandom), 16'($urandom));
    send_item(CMD_REUSE, 16'h0101, 16'($urandom));
    send_item(CMD_REUSE, 16'h0200, 16'($urandom));
    send_item(CMD_REUSE, 16'h0111, 16'($urandom));
    send_item(CMD_REUSE, 16'hffff, 16'($urandom));
    send_item(CMD_REUSE, 16'h0201, 16'($urandom));
    send_item(CMD_REUSE, 16'h0010, 16'($urandom));
    send_item(CMD_RELEASE_ALT, 16'($urandom), 16'h0001);
    send_item(CMD_REUSE, 16'h0101, 16'($urandom));
    send_item(CMD_RELEASE, 16'($urandom), 16'hffc0);
    send_item(CMD_RELEASE, 16'hffff, 16'hffff);
    repeat (SLOTS) send_item(CMD_ALLOC, 16'h0000, 16'h0000);
    send_item(CMD_ALLOC, 16'hffff, 16'hffff);
    send_item(CMD_REUSE, 16'h0000, 16'($urandom));
    send_item(CMD_REUSE, 16'h0301, 16'($urandom));
  endtask

  task automatic send_random_request();
    int pick;
    logic [HANDLE_W-1:0] h;
    logic [REL_W-1:0] m;
    pick = $urandom_range(99);
    h = 16'($urandom);
    m = 16'($urandom);
    if (pick < 4) begin
      repeat ($urandom_range(16, 6)) send_item(CMD_ALLOC, 16'($urandom), 16'($urandom));
    end else if (pick < 38) begin
      send_item(CMD_ALLOC, h, m);
    end else if (pick < 68) begin
      if (ledger.recent_handles.size() != 0 && $urandom_range(99) < 65) begin
        h = ledger.recent_handles[$urandom_range(ledger.recent_handles.size() - 1)];
        if ($urandom_range(4) == 0) h[15:8] = h[15:8] + 8'($urandom_range(255, 1));
      end else if ($urandom_range(1) == 1) begin
        h[7:0] = 8'($urandom_range(SLOTS + 1));
      end
      send_item(CMD_REUSE, h, m);
    end else begin
      case ($urandom_range(3))
        0: m = 16'd1 << $urandom_range(SLOTS - 1);
        1: m = '1;
        default: ;
      endcase
      send_item(pick < 94 ? CMD_RELEASE : CMD_RELEASE_ALT, h, m);
    end
  endtask

  // Slot zero is taken and freed over and over so that its generation count wraps.
  task automatic run_wrap_churn();
    send_item(CMD_RELEASE, 16'($urandom), '1);
    repeat (260) begin
      if ($urandom_range(3) == 0) send_item(CMD_REUSE, 16'($urandom), 16'($urandom));
      else send_item(CMD_ALLOC, 16'($urandom), 16'($urandom));
      send_item(CMD_RELEASE, 16'($urandom), 16'($urandom) | 16'h0001);
    end
  endtask

  initial begin
    ledger = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_drained();
    hold_req <= 1'b1;
    repeat (120) send_random_request();
    steady <= 1'b1;
    repeat (70) send_random_request();
    steady <= 1'b0;
    wait_drained();
    run_wrap_churn();
    repeat (60) send_random_request();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
